FILE: hdl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared constants and types for the byte ring FIFO
// Data widths, index width, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned SIZE_LOG2_W  = 4;
  localparam int unsigned DEPTH_DEF    = 256;
  localparam int unsigned MAX_READ_DEF = 64;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

endpackage

FILE: hdl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int unsigned WIDTH = brf_pkg::DATA_W,
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo: byte FIFO over a power-of-two ring
// Write, read and peek commands on a byte ring held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start_i high and
//   busy_o low. command_i selects write (store data_in_i), read or peek
//   (deliver up to read_length_i bytes, capped at MAX_READ and the fill).
//   Result channel: each result beat sits on the result ports for exactly
//   one cycle, flagged by result_strobe_o. The receiver cannot stall.
//   Config: cfg_we_i writes size_log2 (clamped to 1..8, capped at DEPTH);
//   the write clears both ring indices. Write only while the block is idle.
// Result timing:
//   Every result beat is registered at the edge that produced it.
//   A write, or a read/peek that delivers no byte, yields one beat. A
//   read/peek delivering n bytes yields n beats, one RAM read per cycle on
//   the single read port; busy_o is high while the bytes after the first are read.
// Reset:
//   Indices and burst count clear, the ring size returns to 256 bytes
//   (or DEPTH if smaller). The RAM is not cleared; never-written bytes read
//   as whatever the RAM holds.
// ----------------------------------------------------------------------------
module byte_ring_fifo #(
  parameter int unsigned DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int unsigned MAX_READ = brf_pkg::MAX_READ_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [brf_pkg::SIZE_LOG2_W-1:0]   cfg_wdata_i,
  // command channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        command_i,
  input  logic [brf_pkg::DATA_W-1:0]        data_in_i,
  input  logic                              burst_end_i,
  input  logic [brf_pkg::LEN_W-1:0]         read_length_i,
  // result channel
  output logic                              result_strobe_o,
  output logic [brf_pkg::DATA_W-1:0]        data_out_o,
  output logic                              data_valid_o,
  output logic                              last_o,
  output logic [brf_pkg::IDX_W-1:0]         transferred_o,
  output logic [brf_pkg::IDX_W-1:0]         fill_level_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [brf_pkg::LEN_W-1:0] MaxRead = brf_pkg::LEN_W'(MAX_READ);
  // largest ring in use: 256 bytes, or the whole RAM if it is smaller
  localparam logic [brf_pkg::IDX_W-1:0] SizeCap =
    (DEPTH >= 256) ? 9'd256 : brf_pkg::IDX_W'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  typedef logic [brf_pkg::IDX_W-1:0] idx_t;
  typedef logic [brf_pkg::LEN_W-1:0] len_t;

  // control state
  state_e state_q, state_d;
  idx_t   size_q, size_d;
  idx_t   wr_idx_q, wr_idx_d;
  idx_t   rd_idx_q, rd_idx_d;
  idx_t   burst_cnt_q, burst_cnt_d;
  // streaming context of the read/peek in flight
  idx_t   ptr_q, ptr_d;
  len_t   cnt_q, cnt_d;
  len_t   num_q, num_d;
  idx_t   used_q, used_d;
  logic   adv_q, adv_d;
  // result beat registers
  logic   res_strobe_q, res_strobe_d;
  logic   res_valid_q, res_valid_d;
  logic   res_last_q, res_last_d;
  idx_t   res_xfer_q, res_xfer_d;
  idx_t   res_fill_q, res_fill_d;

  // combinational helpers
  idx_t                         used;
  logic [7:0]                   mask8;
  idx_t                         bc_new;
  len_t                         lim;
  len_t                         num;
  len_t                         k1;
  idx_t                         rd_pos;
  logic [brf_pkg::SIZE_LOG2_W-1:0] lg_c;
  idx_t                         cfg_size;
  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [brf_pkg::DATA_W-1:0]   ram_rdata;

  assign used  = wr_idx_q - rd_idx_q;
  assign mask8 = 8'(size_q - 9'd1);

  // clamp the requested size and cap it at the RAM depth
  always_comb begin
    lg_c = cfg_wdata_i;
    if (lg_c < 4'd1) begin
      lg_c = 4'd1;
    end else if (lg_c > 4'd8) begin
      lg_c = 4'd8;
    end
    cfg_size = 9'd1 << lg_c;
    if (cfg_size > SizeCap) begin
      cfg_size = SizeCap;
    end
  end

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    burst_cnt_d = burst_cnt_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    used_d      = used_q;
    adv_d       = adv_q;

    res_strobe_d = 1'b0;
    res_valid_d  = 1'b0;
    res_last_d   = 1'b0;
    res_xfer_d   = '0;
    res_fill_d   = '0;

    ram_we = 1'b0;
    ram_re = 1'b0;
    rd_pos = rd_idx_q;
    bc_new = burst_cnt_q;
    k1     = cnt_q + 7'd1;

    // cut the request to MAX_READ, then to what is stored
    lim = (read_length_i > MaxRead) ? MaxRead : read_length_i;
    num = ({2'b00, lim} > used) ? used[brf_pkg::LEN_W-1:0] : lim;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (brf_pkg::cmd_e'(command_i)) inside
            brf_pkg::CMD_WRITE: begin
              // store only when there is room; a refused byte is dropped
              if (used < size_q) begin
                ram_we   = 1'b1;
                wr_idx_d = wr_idx_q + 9'd1;
                bc_new   = (burst_cnt_q == '1) ? burst_cnt_q : burst_cnt_q + 9'd1;
              end
              res_strobe_d = 1'b1;
              res_last_d   = burst_end_i;
              res_xfer_d   = bc_new;
              res_fill_d   = wr_idx_d - rd_idx_q;
              burst_cnt_d  = burst_end_i ? '0 : bc_new;
            end
            brf_pkg::CMD_READ, brf_pkg::CMD_PEEK: begin
              res_strobe_d = 1'b1;
              if (num == '0) begin
                // nothing to deliver: one empty closing beat
                res_last_d = 1'b1;
                res_fill_d = used;
              end else begin
                // issue the first byte now, stream the rest
                ram_re      = 1'b1;
                rd_pos      = rd_idx_q;
                adv_d       = (command_i == brf_pkg::CMD_READ);
                res_valid_d = 1'b1;
                res_last_d  = (num == 7'd1);
                res_xfer_d  = 9'd1;
                res_fill_d  = adv_d ? used - 9'd1 : used;
                ptr_d       = rd_idx_q + 9'd1;
                cnt_d       = 7'd1;
                num_d       = num;
                used_d      = used;
                if (adv_d) begin
                  rd_idx_d = rd_idx_q + {2'b00, num};
                end
                if (num != 7'd1) begin
                  state_d = ST_STREAM;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        ram_re      = 1'b1;
        rd_pos      = ptr_q;
        res_strobe_d = 1'b1;
        res_valid_d  = 1'b1;
        res_last_d   = (k1 == num_q);
        res_xfer_d   = {2'b00, k1};
        res_fill_d   = adv_q ? used_q - {2'b00, k1} : used_q;
        ptr_d        = ptr_q + 9'd1;
        cnt_d        = k1;
        if (k1 == num_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a size write restarts the ring empty; the burst count survives
    if (cfg_we_i) begin
      size_d   = cfg_size;
      wr_idx_d = '0;
      rd_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      size_q       <= SizeCap;
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      burst_cnt_q  <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      num_q        <= '0;
      used_q       <= '0;
      adv_q        <= 1'b0;
      res_strobe_q <= 1'b0;
      res_valid_q  <= 1'b0;
      res_last_q   <= 1'b0;
      res_xfer_q   <= '0;
      res_fill_q   <= '0;
    end else begin
      state_q      <= state_d;
      size_q       <= size_d;
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      burst_cnt_q  <= burst_cnt_d;
      ptr_q        <= ptr_d;
      cnt_q        <= cnt_d;
      num_q        <= num_d;
      used_q       <= used_d;
      adv_q        <= adv_d;
      res_strobe_q <= res_strobe_d;
      res_valid_q  <= res_valid_d;
      res_last_q   <= res_last_d;
      res_xfer_q   <= res_xfer_d;
      res_fill_q   <= res_fill_d;
    end
  end

  // ring position: index masked by the size in use, sized to the RAM address
  assign ram_waddr = AW'(wr_idx_q[7:0] & mask8);
  assign ram_raddr = AW'(rd_pos[7:0] & mask8);

  brf_ram #(
    .WIDTH (brf_pkg::DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_in_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o          = (state_q == ST_STREAM);
  assign result_strobe_o = res_strobe_q;
  assign data_valid_o    = res_valid_q;
  assign data_out_o      = res_valid_q ? ram_rdata : '0;
  assign last_o          = res_last_q;
  assign transferred_o   = res_xfer_q;
  assign fill_level_o    = res_fill_q;

  // the ring never holds more than its size in use
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= size_q)
    else $error("fill level exceeds ring size");

  // a streaming read never runs past its byte count
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> (cnt_q < num_q))
    else $error("stream counter past byte count");

  // the closing beat of a delivering read leaves the block free
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && data_valid_o && last_o) |-> !busy_o)
    else $error("busy after final read beat");

  // a write command yields exactly one beat without ring data
  a_write_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == brf_pkg::CMD_WRITE)
      |=> (result_strobe_o && !data_valid_o))
    else $error("write beat malformed");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for byte_ring_fifo
// Drives write, read and peek commands through the start/busy handshake and
// checks every result beat against a shadow copy of the ring. A short table
// of directed rows runs first. Random phases follow at several ring sizes.
// A closing stretch without gaps stores more than one capped read can take
// and then overfills a small ring.
// ----------------------------------------------------------------------------
module tb_top;
  import brf_pkg::*;

  localparam int unsigned RING_MAX   = DEPTH_DEF;
  localparam int unsigned RING_AW    = $clog2(RING_MAX);
  localparam int unsigned READ_CAP   = MAX_READ_DEF;
  // quiet cycles after the last beat before a size write and at the end
  localparam int unsigned SETTLE_CYC = 8;
  localparam int unsigned PHASE_BEATS = 14;

  // one result beat, field for field as the block presents it
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  xfer;
    logic [IDX_W-1:0]  level;
  } beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // one row of the directed table; typed rows carry their single beat
  typedef struct {
    row_kind_e              kind;
    cmd_e                   cmd;
    logic [DATA_W-1:0]      data;
    logic                   burst_end;
    logic [LEN_W-1:0]       len;
    logic [SIZE_LOG2_W-1:0] lg;
    bit                     typed;
    beat_t                  beat;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [SIZE_LOG2_W-1:0] cfg_wdata_i;
  logic                   start_i;
  logic                   busy_o;
  logic [1:0]             command_i;
  logic [DATA_W-1:0]      data_in_i;
  logic                   burst_end_i;
  logic [LEN_W-1:0]       read_length_i;
  logic                   result_strobe_o;
  logic [DATA_W-1:0]      data_out_o;
  logic                   data_valid_o;
  logic                   last_o;
  logic [IDX_W-1:0]       transferred_o;
  logic [IDX_W-1:0]       fill_level_o;

  byte_ring_fifo i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .data_in_i      (data_in_i),
    .burst_end_i    (burst_end_i),
    .read_length_i  (read_length_i),
    .result_strobe_o(result_strobe_o),
    .data_out_o     (data_out_o),
    .data_valid_o   (data_valid_o),
    .last_o         (last_o),
    .transferred_o  (transferred_o),
    .fill_level_o   (fill_level_o)
  );

  // 12 ns period
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow ring: the bench's own copy of store, indices, burst count and size
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0]      ring_copy [RING_MAX];
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       burst_run;
  logic [SIZE_LOG2_W-1:0] lg_reg;

  // beats still owed by the block, oldest first
  beat_t due_beats [$];
  int    errors;
  bit    idle_on;

  // Work out the beats one accepted command causes and queue them.
  task automatic predict_fifo_beats(cmd_e c, logic [DATA_W-1:0] d, logic e,
                                    logic [LEN_W-1:0] len);
    int unsigned      lg;
    int unsigned      ring_bytes;
    int unsigned      take;
    logic [IDX_W-1:0] used;
    logic [IDX_W-1:0] mask;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] after;
    // clamp the size to 1..8 and cap it at the ring depth
    lg = (lg_reg < 1) ? 1 : (lg_reg > 8) ? 8 : lg_reg;
    ring_bytes = 1 << lg;
    if (ring_bytes > RING_MAX) ring_bytes = RING_MAX;
    mask = IDX_W'(ring_bytes - 1);
    // free-running 9-bit indices: the difference wraps by itself
    used = wr_idx - rd_idx;
    case (c) inside
      CMD_WRITE: begin
        // store only with free space; a refused byte leaves the count alone
        if (used < ring_bytes) begin
          ring_copy[RING_AW'(wr_idx & mask)] = d;
          wr_idx = wr_idx + 1'b1;
          if (burst_run != '1) burst_run = burst_run + 1'b1;
        end
        due_beats.push_back(beat_t'{data: '0, valid: 1'b0, last: e, xfer: burst_run,
                                    level: IDX_W'(wr_idx - rd_idx)});
        // the count clears only after the closing beat has reported it
        if (e) burst_run = '0;
      end
      CMD_READ, CMD_PEEK: begin
        take = len;
        if (take > READ_CAP) take = READ_CAP;
        if (take > used) take = used;
        if (take == 0) begin
          // nothing to hand out: one empty closing beat
          due_beats.push_back(beat_t'{data: '0, valid: 1'b0, last: 1'b1, xfer: '0,
                                      level: used});
        end else begin
          for (int k = 0; k < take; k++) begin
            pos   = (rd_idx + IDX_W'(k)) & mask;
            after = (c == CMD_READ) ? used - IDX_W'(k + 1) : used;
            due_beats.push_back(beat_t'{data: ring_copy[RING_AW'(pos)], valid: 1'b1,
                                        last: (k + 1 == take), xfer: IDX_W'(k + 1),
                                        level: after});
          end
          // a peek leaves the read index where it was
          if (c == CMD_READ) rd_idx = rd_idx + IDX_W'(take);
        end
      end
      default: ; // unused command: no beat, no change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobed beat is matched to the oldest one owed
  // --------------------------------------------------------------------------
  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : beat_check
    beat_t want;
    if (rst_ni && result_strobe_o) begin
      if (due_beats.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual data 0x%0h last %0b",
                 $time, data_out_o, last_o);
        errors++;
      end else begin
        want = due_beats.pop_front();
        cmp_field("data_out",    16'(want.data),  16'(data_out_o));
        cmp_field("data_valid",  16'(want.valid), 16'(data_valid_o));
        cmp_field("last",        16'(want.last),  16'(last_o));
        cmp_field("transferred", 16'(want.xfer),  16'(transferred_o));
        cmp_field("fill_level",  16'(want.level), 16'(fill_level_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command driver. Call at a falling edge; returns at a falling edge with
  // start still high, so back-to-back commands keep start up without a dip.
  // --------------------------------------------------------------------------
  task automatic issue_cmd(cmd_e c, logic [DATA_W-1:0] d, logic e, logic [LEN_W-1:0] len);
    // insert a short sender gap now and then
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start_i       <= 1'b1;
    command_i     <= c;
    data_in_i     <= d;
    burst_end_i   <= e;
    read_length_i <= len;
    // the beat is taken at the first rising edge that sees busy low
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_fifo_beats(c, d, e, len);
    @(negedge clk_i);
  endtask

  // Drop start, let every owed beat arrive, settle, then write the size.
  task automatic write_size(logic [SIZE_LOG2_W-1:0] v);
    start_i <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // the write clears both indices; the burst count survives
    lg_reg = v;
    wr_idx = '0;
    rd_idx = '0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table: extremes, each command, full ring, empty ring, zero
  // length, oversize requests, clamped sizes and a burst across a size write
  // --------------------------------------------------------------------------
  stim_row_t dir_rows [] = '{
    // empty after reset: read and peek give one empty closing beat
    '{ROW_ITEM, CMD_READ,  8'h00, 1'b0, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd0, 9'd0}},
    '{ROW_ITEM, CMD_PEEK,  8'h00, 1'b0, 7'd5,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd0, 9'd0}},
    // unused command: ignored
    '{ROW_ITEM, CMD_NONE,  8'h5A, 1'b1, 7'd9,   4'd0,  1'b0, '0},
    // data extremes, then a peek asking far beyond the cap and a read at the cap
    '{ROW_ITEM, CMD_WRITE, 8'h00, 1'b0, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 9'd1, 9'd1}},
    '{ROW_ITEM, CMD_WRITE, 8'hFF, 1'b1, 7'd127, 4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd2, 9'd2}},
    '{ROW_ITEM, CMD_PEEK,  8'h00, 1'b0, 7'd127, 4'd0,  1'b0, '0},
    '{ROW_ITEM, CMD_READ,  8'h00, 1'b0, 7'd64,  4'd0,  1'b0, '0},
    // size 0 clamps to a two-byte ring; the third byte is refused
    '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 7'd0,   4'd0,  1'b0, '0},
    '{ROW_ITEM, CMD_WRITE, 8'hA5, 1'b0, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 9'd1, 9'd1}},
    '{ROW_ITEM, CMD_WRITE, 8'h5A, 1'b0, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 9'd2, 9'd2}},
    '{ROW_ITEM, CMD_WRITE, 8'h3C, 1'b1, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd2, 9'd2}},
    '{ROW_ITEM, CMD_READ,  8'h00, 1'b0, 7'd1,   4'd0,  1'b1, '{8'hA5, 1'b1, 1'b1, 9'd1, 9'd1}},
    // wrap around the small ring
    '{ROW_ITEM, CMD_WRITE, 8'h96, 1'b1, 7'd0,   4'd0,  1'b0, '0},
    '{ROW_ITEM, CMD_PEEK,  8'h00, 1'b0, 7'd3,   4'd0,  1'b0, '0},
    '{ROW_ITEM, CMD_READ,  8'h00, 1'b0, 7'd127, 4'd0,  1'b0, '0},
    // size 15 clamps to the full ring; zero-length read reports the fill
    '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 7'd0,   4'd15, 1'b0, '0},
    '{ROW_ITEM, CMD_WRITE, 8'h81, 1'b0, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 9'd1, 9'd1}},
    '{ROW_ITEM, CMD_READ,  8'h00, 1'b0, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd0, 9'd1}},
    // a size write clears the indices but the open burst keeps counting
    '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 7'd0,   4'd1,  1'b0, '0},
    '{ROW_ITEM, CMD_WRITE, 8'h42, 1'b1, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd2, 9'd1}},
    '{ROW_CFG,  CMD_NONE,  8'h00, 1'b0, 7'd0,   4'd8,  1'b0, '0},
    '{ROW_ITEM, CMD_WRITE, 8'h7E, 1'b1, 7'd0,   4'd0,  1'b1, '{8'h00, 1'b0, 1'b1, 9'd1, 9'd1}},
    '{ROW_ITEM, CMD_PEEK,  8'h00, 1'b0, 7'd1,   4'd0,  1'b1, '{8'h7E, 1'b1, 1'b1, 9'd1, 9'd1}},
    '{ROW_ITEM, CMD_READ,  8'h00, 1'b0, 7'd1,   4'd0,  1'b1, '{8'h7E, 1'b1, 1'b1, 9'd1, 9'd0}}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int                     sent;
    int                     pick;
    cmd_e                   c;
    logic [LEN_W-1:0]       len;
    logic [SIZE_LOG2_W-1:0] lg;

    // every input known from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start_i       = 1'b0;
    command_i     = CMD_NONE;
    data_in_i     = '0;
    burst_end_i   = 1'b0;
    read_length_i = '0;
    errors        = 0;
    idle_on       = 1'b1;
    wr_idx        = '0;
    rd_idx        = '0;
    burst_run     = '0;
    lg_reg        = 4'd8;

    // hold reset, then release it on a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; typed rows replace the predicted beat with their own
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_size(dir_rows[i].lg);
      end else begin
        issue_cmd(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].burst_end, dir_rows[i].len);
        if (dir_rows[i].typed) due_beats[due_beats.size() - 1] = dir_rows[i].beat;
      end
    end

    // random phases at several ring sizes, both extremes and an arbitrary one
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       lg = 4'd3;
        1:       lg = 4'd1;
        2:       lg = SIZE_LOG2_W'($urandom_range(0, 15));
        3:       lg = 4'd8;
        default: lg = 4'd2;
      endcase
      write_size(lg);
      idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        // mostly short requests, sometimes anything the field allows
        len = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(0, 6))
                                         : LEN_W'($urandom_range(0, 127));
        if (pick < 55)      c = CMD_WRITE;
        else if (pick < 75) c = CMD_READ;
        else if (pick < 95) c = CMD_PEEK;
        else                c = CMD_NONE;
        issue_cmd(c, DATA_W'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0), len);
        if (c != CMD_NONE) sent++;
      end
    end

    // closing stretch with no gaps: store more bytes than one read may take
    // so a long read is cut at the cap, then overfill a four-byte ring
    idle_on = 1'b0;
    write_size(4'd7);
    repeat (66) issue_cmd(CMD_WRITE, DATA_W'($urandom_range(0, 255)), 1'b0,
                          LEN_W'($urandom_range(0, 127)));
    issue_cmd(CMD_WRITE, DATA_W'($urandom_range(0, 255)), 1'b1, '0);
    repeat (2) issue_cmd(CMD_READ, '0, 1'b0, 7'd127);
    write_size(4'd2);
    repeat (6) issue_cmd(CMD_WRITE, DATA_W'($urandom_range(0, 255)), 1'b0, '0);
    issue_cmd(CMD_PEEK, '0, 1'b0, 7'd127);
    issue_cmd(CMD_READ, '0, 1'b0, 7'd127);

    // let the last beats arrive, then a few quiet cycles
    start_i <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
